FILE: src/assert_macros.svh
// assertion helper macros for the button gesture recognizer
// expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define BGR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define BGR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: src/bgr_pkg.sv
// shared types and codes for the button gesture recognizer
// no dependencies
`default_nettype none

package bgr_pkg;

    localparam int unsigned NumBtn = 3;

    localparam logic [15:0] LONG_HOLD_RST = 16'd1000;

    localparam logic [2:0] FUNC_PRESS    = 3'd0;
    localparam logic [2:0] FUNC_LONG     = 3'd1;
    localparam logic [2:0] FUNC_RELEASE  = 3'd2;
    localparam logic [2:0] FUNC_CLICK    = 3'd3;
    localparam logic [2:0] FUNC_SUPPRESS = 3'd4;
    localparam logic [2:0] FUNC_CLEAR    = 3'd5;

    localparam logic [1:0] BTN_UP      = 2'd0;
    localparam logic [1:0] BTN_DOWN    = 2'd1;
    localparam logic [1:0] BTN_CONFIRM = 2'd2;
    localparam logic [1:0] BTN_NONE    = 2'd3;

    localparam logic [2:0] GEST_NONE     = 3'd0;
    localparam logic [2:0] GEST_UP_CLICK = 3'd1;
    localparam logic [2:0] GEST_UP_LONG  = 3'd4;
    localparam logic [2:0] GEST_COMBO    = 3'd7;

    typedef enum logic [2:0] {
        OP_PRESS,
        OP_LONG,
        OP_RELEASE,
        OP_CLICK,
        OP_SUPPRESS,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [1:0]  button;
        logic [31:0] now_ms;
    } t_evt;

    // front to back
    typedef struct packed {
        logic empty;
        t_evt evt;
    } t_front_out;

    typedef struct packed {
        logic [2:0] gesture;
        logic [2:0] held_mask;
        logic [2:0] suppress_mask;
    } t_res;

endpackage

`default_nettype wire

FILE: src/button_gesture_recognizer_unit.sv
// Button gesture recognizer: takes press, long-start, release, click, suppress and
// clear beats for three buttons and returns one result beat per event with the
// gesture code and the held and suppress masks after that event. Both sides are
// queues; an event can enter every clock cycle while the front queue is not full
// and its result is ready to pop after the front queue, the state update and the
// result queue. Sustained rate is one event per cycle while results are popped,
// set by the back part's state update. The long-hold threshold is written by the
// user via i_cfg_we and i_cfg_wdata only while no event is in flight; the block does not enforce it.
// depends on bgr_pkg, bgr_front and bgr_back
`default_nettype none

module button_gesture_recognizer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_func,
    input  wire logic [1:0]  i_button,
    input  wire logic [31:0] i_now_ms,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_gesture,
    output logic [2:0]       o_held_mask,
    output logic [2:0]       o_suppress_mask
);

    bgr_pkg::t_front_out w_front;
    logic                w_take;

    bgr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_func   (i_func),
        .i_button (i_button),
        .i_now_ms (i_now_ms),
        .o_front  (w_front),
        .i_take   (w_take)
    );

    bgr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_front         (w_front),
        .o_take          (w_take),
        .empty           (empty),
        .pop             (pop),
        .o_gesture       (o_gesture),
        .o_held_mask     (o_held_mask),
        .o_suppress_mask (o_suppress_mask)
    );

endmodule

`default_nettype wire

FILE: src/bgr_front.sv
// front part: accepts and classifies button event beats into a two-entry queue
// depends on bgr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bgr_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [2:0]        i_func,
    input  wire logic [1:0]        i_button,
    input  wire logic [31:0]       i_now_ms,
    output bgr_pkg::t_front_out    o_front,
    input  wire logic              i_take
);

    bgr_pkg::t_evt r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_cnt;
    logic          w_acc;
    logic          w_take;
    bgr_pkg::t_op  w_op;

    always_comb begin
        if (i_func == bgr_pkg::FUNC_CLEAR) begin
            w_op = bgr_pkg::OP_CLEAR;
        end else if (i_button == bgr_pkg::BTN_NONE) begin
            w_op = bgr_pkg::OP_NOP;
        end else begin
            unique case (i_func)
                bgr_pkg::FUNC_PRESS:    w_op = bgr_pkg::OP_PRESS;
                bgr_pkg::FUNC_LONG:     w_op = bgr_pkg::OP_LONG;
                bgr_pkg::FUNC_RELEASE:  w_op = bgr_pkg::OP_RELEASE;
                bgr_pkg::FUNC_CLICK:    w_op = bgr_pkg::OP_CLICK;
                bgr_pkg::FUNC_SUPPRESS: w_op = bgr_pkg::OP_SUPPRESS;
                default:                w_op = bgr_pkg::OP_NOP;
            endcase
        end
    end

    assign full          = (r_cnt == 2'd2);
    assign w_acc         = push && !full;
    assign o_front.empty = (r_cnt == 2'd0);
    assign o_front.evt   = r_mem[r_rd_ptr];
    assign w_take        = i_take && !o_front.empty;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[r_wr_ptr] <= '{op: w_op, button: i_button, now_ms: i_now_ms};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_acc) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, w_take};
        end
    end

    `BGR_ASSERT(a_front_cnt_bound, r_cnt != 2'd3, "front queue count overflow")
    `BGR_ASSERT_ALWAYS(a_front_rst_empty, !i_rst_n |=> r_cnt == 2'd0, "front queue not empty after reset")

endmodule

`default_nettype wire

FILE: src/bgr_back.sv
// back part: per-button state, gesture decision and a two-entry result queue
// depends on bgr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bgr_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [15:0]            i_cfg_wdata,
    input  bgr_pkg::t_front_out         i_front,
    output logic                        o_take,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [2:0]                  o_gesture,
    output logic [2:0]                  o_held_mask,
    output logic [2:0]                  o_suppress_mask
);

    localparam int unsigned NB = bgr_pkg::NumBtn;

    logic [15:0]     r_long_hold;
    logic [NB-1:0]   r_held,     n_held;
    logic [31:0]     r_start [NB];
    logic [NB-1:0]   r_valid,    n_valid;
    logic [NB-1:0]   r_long_rep, n_long_rep;
    logic [NB-1:0]   r_supp,     n_supp;
    logic            r_combo,    n_combo;
    logic [2:0]      n_gest;

    bgr_pkg::t_res   r_res [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_ocnt;
    logic            w_pop;

    logic [1:0]      w_b;
    logic [1:0]      w_oth;
    logic            w_pair;
    logic [31:0]     w_dur;
    logic            w_is_long;
    logic            w_do_long;
    logic            w_combo_hit;
    logic            w_rel_up;

    assign w_b       = i_front.evt.button;
    assign w_oth     = {1'b0, ~w_b[0]};
    assign w_pair    = ~w_b[1];
    assign w_dur     = i_front.evt.now_ms - r_start[w_b];
    assign w_is_long = r_valid[w_b] && (w_dur >= {16'd0, r_long_hold});

    assign o_take = !i_front.empty && (r_ocnt != 2'd2);
    assign w_pop  = pop && !empty;

    always_comb begin
        n_held     = r_held;
        n_valid    = r_valid;
        n_long_rep = r_long_rep;
        n_supp     = r_supp;
        n_combo    = r_combo;
        n_gest     = bgr_pkg::GEST_NONE;
        w_do_long  = 1'b0;
        unique case (i_front.evt.op)
            bgr_pkg::OP_PRESS: begin
                if (w_pair && !r_held[w_oth]) begin
                    n_combo = 1'b0;
                end
                n_held[w_b]     = 1'b1;
                n_valid[w_b]    = 1'b1;
                n_long_rep[w_b] = 1'b0;
                n_supp[w_b]     = 1'b0;
            end
            bgr_pkg::OP_LONG: begin
                if (!r_long_rep[w_b]) begin
                    n_long_rep[w_b] = 1'b1;
                    n_supp[w_b]     = 1'b1;
                    w_do_long       = 1'b1;
                end
            end
            bgr_pkg::OP_RELEASE: begin
                n_valid[w_b] = 1'b0;
                if (w_is_long && !r_long_rep[w_b]) begin
                    n_long_rep[w_b] = 1'b1;
                    n_supp[w_b]     = 1'b1;
                    w_do_long       = 1'b1;
                end
                n_held[w_b] = 1'b0;
            end
            bgr_pkg::OP_CLICK: begin
                if (r_supp[w_b]) begin
                    n_supp[w_b] = 1'b0;
                end else begin
                    n_gest = bgr_pkg::GEST_UP_CLICK + {1'b0, w_b};
                end
            end
            bgr_pkg::OP_SUPPRESS: begin
                n_supp[w_b] = 1'b1;
            end
            bgr_pkg::OP_CLEAR: begin
                n_held     = '0;
                n_valid    = '0;
                n_long_rep = '0;
                n_supp     = '0;
                n_combo    = 1'b0;
            end
            default: begin
            end
        endcase
        if (w_do_long) begin
            // long hold on one nav key while the other is held
            if (w_pair && r_held[w_oth]) begin
                if (!r_combo) begin
                    n_combo         = 1'b1;
                    n_long_rep[1:0] = 2'b11;
                    n_supp[1:0]     = 2'b11;
                    n_gest          = bgr_pkg::GEST_COMBO;
                end
            end else begin
                n_gest = bgr_pkg::GEST_UP_LONG + {1'b0, w_b};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && (i_front.evt.op == bgr_pkg::OP_PRESS)) begin
            r_start[w_b] <= i_front.evt.now_ms;
        end
        if (o_take) begin
            r_res[r_wp] <= '{gesture: n_gest, held_mask: n_held, suppress_mask: n_supp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_hold <= bgr_pkg::LONG_HOLD_RST;
            r_held      <= '0;
            r_valid     <= '0;
            r_long_rep  <= '0;
            r_supp      <= '0;
            r_combo     <= 1'b0;
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_ocnt      <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_long_hold <= i_cfg_wdata;
            end
            if (o_take) begin
                r_held     <= n_held;
                r_valid    <= n_valid;
                r_long_rep <= n_long_rep;
                r_supp     <= n_supp;
                r_combo    <= n_combo;
                r_wp       <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_ocnt <= r_ocnt + {1'b0, o_take} - {1'b0, w_pop};
        end
    end

    assign empty           = (r_ocnt == 2'd0);
    assign o_gesture       = r_res[r_rp].gesture;
    assign o_held_mask     = r_res[r_rp].held_mask;
    assign o_suppress_mask = r_res[r_rp].suppress_mask;

    assign w_combo_hit = o_take && (n_gest == bgr_pkg::GEST_COMBO);
    assign w_rel_up    = o_take && (i_front.evt.op == bgr_pkg::OP_RELEASE)
                         && (w_b == bgr_pkg::BTN_UP);

    `BGR_ASSERT(a_back_combo_supp, w_combo_hit |=> &r_supp[1:0] && r_combo, "combo flags unset")
    `BGR_ASSERT(a_back_release_valid, w_rel_up |=> !r_valid[bgr_pkg::BTN_UP], "start still valid")

endmodule

`default_nettype wire
